// File: hw/rtl/crcmb_pkg.sv
// Shared types, constants and functions of the CRC-16/MODBUS hex framer.
// Used by crcmb_front, crcmb_queue, crcmb_back and the framer core; no dependencies.
`default_nettype none

package crcmb_pkg;

    // CRC-16/MODBUS: reflected polynomial, all-ones start value
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // framing characters
    localparam logic [7:0] CH_OPEN  = 8'h40;   // '@'
    localparam logic [7:0] CH_SEP   = 8'h3A;   // ':'
    localparam logic [7:0] CH_CLOSE = 8'h26;   // '&'
    localparam logic [7:0] CH_ZERO  = 8'h30;   // '0'
    localparam logic [7:0] CH_A     = 8'h41;   // 'A'

    // default depth of the request queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // one classified request handed from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        first;   // opens a frame: '@' goes out before the byte
        logic        last;    // closes a frame: ':' HHHH '&' follow the byte
        logic [15:0] crc;     // CRC after this byte, used when last is set
    } queue_entry_t;

    // character sequencer of the back end
    typedef enum logic [2:0] {
        PH_OPEN,
        PH_BYTE,
        PH_SEP,
        PH_HEX3,
        PH_HEX2,
        PH_HEX1,
        PH_HEX0,
        PH_CLOSE
    } phase_t;

    // one byte through the LSB-first CRC, eight shift/xor steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // nibble to upper-case ASCII hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10)
            r = CH_ZERO + {4'h0, v};
        else
            r = CH_A + {4'h0, v} - 8'd10;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/crc16_modbus_hex_framer_core.sv
// A request's first character ('@' or the byte) goes through the queue and the output register
// before it is on out_char. Throughput: one character per cycle from the back-end sequencer
// while the queue holds a request and out_ready allows. A frame's first byte adds '@', its last byte
// adds ':' HHHH '&'. The front takes a byte per cycle while the QUEUE_DEPTH-entry queue has room.
// Reset: asynchronous, active low; clears the queue, the output valid and the sequencer,
// sets the CRC to 0xFFFF and waits for the first byte of a frame.
`default_nettype none

module crc16_modbus_hex_framer_core
#(
    parameter int QUEUE_DEPTH = crcmb_pkg::QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_char,
    output logic            end_of_frame
);

    crcmb_pkg::queue_entry_t push_entry;
    crcmb_pkg::queue_entry_t head;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;

    crcmb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    crcmb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .empty      (queue_empty),
        .head       (head)
    );

    crcmb_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_char     (out_char),
        .end_of_frame (end_of_frame)
    );

endmodule

`default_nettype wire

// File: hw/rtl/crcmb_front.sv
// Front end of the framer: takes payload bytes, tracks frame position, runs the CRC.
// Depends on crcmb_pkg; feeds crcmb_queue.
`default_nettype none

module crcmb_front
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   last_byte,
    input  wire logic                   queue_full,
    output logic                        push,
    output crcmb_pkg::queue_entry_t     push_entry
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        in_frame_reg;
    logic        in_frame_next;
    logic [15:0] crc_base;
    logic [15:0] crc_upd;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    // a new frame restarts from the initial value
    assign crc_base = in_frame_reg ? crc_reg : crcmb_pkg::CRC_INIT;
    assign crc_upd  = crcmb_pkg::crc_byte(crc_base, data_byte);

    // classified request
    always_comb
    begin
        push_entry.data  = data_byte;
        push_entry.first = !in_frame_reg;
        push_entry.last  = last_byte;
        push_entry.crc   = crc_upd;
    end

    // frame tracking and running CRC
    always_comb
    begin
        crc_next      = crc_reg;
        in_frame_next = in_frame_reg;
        if (push)
        begin
            if (last_byte)
            begin
                crc_next      = crcmb_pkg::CRC_INIT;
                in_frame_next = 1'b0;
            end
            else
            begin
                crc_next      = crc_upd;
                in_frame_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= crcmb_pkg::CRC_INIT;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            crc_reg      <= crc_next;
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/crcmb_queue.sv
// Short request queue between front and back of the framer.
// Depends on crcmb_pkg for the entry type.
`default_nettype none

module crcmb_queue
#(
    parameter int DEPTH = crcmb_pkg::QUEUE_DEPTH   // 2 or more
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire crcmb_pkg::queue_entry_t push_entry,
    input  wire logic                   pop,
    output logic                        full,
    output logic                        empty,
    output crcmb_pkg::queue_entry_t     head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    crcmb_pkg::queue_entry_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// File: hw/rtl/crcmb_back.sv
// Back end of the framer: expands each queued request into framing, payload and hex CRC chars.
// Depends on crcmb_pkg; reads crcmb_queue and drives the output register.
`default_nettype none

module crcmb_back
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    queue_empty,
    input  wire crcmb_pkg::queue_entry_t head,
    output logic                         pop,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [7:0]                   out_char,
    output logic                         end_of_frame
);

    crcmb_pkg::phase_t phase_reg;
    crcmb_pkg::phase_t phase_next;
    crcmb_pkg::phase_t cur_phase;
    crcmb_pkg::phase_t adv_phase;
    logic       mid_reg;        // head request partly sent
    logic       mid_next;
    logic       load;
    logic       done;
    logic [7:0] ch;
    logic       eof;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_char_reg;
    logic       eof_reg;

    // where the head request stands
    assign cur_phase = mid_reg ? phase_reg
                     : (head.first ? crcmb_pkg::PH_OPEN : crcmb_pkg::PH_BYTE);
    assign load = !queue_empty && (!out_valid_reg || out_ready);
    assign pop  = load && done;

    // character select and sequencer
    always_comb
    begin
        ch        = crcmb_pkg::CH_OPEN;
        eof       = 1'b0;
        done      = 1'b0;
        adv_phase = cur_phase;
        case (cur_phase)
            crcmb_pkg::PH_OPEN:
            begin
                ch        = crcmb_pkg::CH_OPEN;
                adv_phase = crcmb_pkg::PH_BYTE;
            end
            crcmb_pkg::PH_BYTE:
            begin
                ch        = head.data;
                adv_phase = crcmb_pkg::PH_SEP;
                done      = !head.last;
            end
            crcmb_pkg::PH_SEP:
            begin
                ch        = crcmb_pkg::CH_SEP;
                adv_phase = crcmb_pkg::PH_HEX3;
            end
            crcmb_pkg::PH_HEX3:
            begin
                ch        = crcmb_pkg::hex_char(head.crc[15:12]);
                adv_phase = crcmb_pkg::PH_HEX2;
            end
            crcmb_pkg::PH_HEX2:
            begin
                ch        = crcmb_pkg::hex_char(head.crc[11:8]);
                adv_phase = crcmb_pkg::PH_HEX1;
            end
            crcmb_pkg::PH_HEX1:
            begin
                ch        = crcmb_pkg::hex_char(head.crc[7:4]);
                adv_phase = crcmb_pkg::PH_HEX0;
            end
            crcmb_pkg::PH_HEX0:
            begin
                ch        = crcmb_pkg::hex_char(head.crc[3:0]);
                adv_phase = crcmb_pkg::PH_CLOSE;
            end
            crcmb_pkg::PH_CLOSE:
            begin
                ch   = crcmb_pkg::CH_CLOSE;
                eof  = 1'b1;
                done = 1'b1;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase

        phase_next = phase_reg;
        mid_next   = mid_reg;
        if (load)
        begin
            phase_next = adv_phase;
            mid_next   = !done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= crcmb_pkg::PH_OPEN;
            mid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            mid_reg   <= mid_next;
        end
    end

    // output register
    assign out_valid_next = load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= ch;
            eof_reg      <= eof;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign end_of_frame = eof_reg;

    a_eof_is_close: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_frame) |-> (out_char == crcmb_pkg::CH_CLOSE))
        else $error("end_of_frame on a character other than the close");

    a_pop_ends_mid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !mid_reg)
        else $error("sequencer still mid-request after pop");

    a_mid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        mid_reg |-> !queue_empty)
        else $error("partly sent request left the queue");

endmodule

`default_nettype wire

// File: tb/crc16_modbus_hex_framer_core_test.sv
// Self-checking testbench for crc16_modbus_hex_framer_core: sends payload frames under random
// gaps and back-pressure, predicts the '@' payload ':' HHHH '&' stream, checks each character.
// Depends on crcmb_pkg and the framer core RTL.

module crc16_modbus_hex_framer_core_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 85;

    // one expected character of the framed stream
    typedef struct packed {
        logic [7:0] ch;
        logic       eof;
    } frame_char_t;

    // tracks the running CRC and holds the characters still owed by the block
    class frame_scoreboard;
        logic [15:0] crc;
        bit          frame_open;
        frame_char_t owed_chars[$];
        int          mismatches;
        int          chars_checked;
        int          bytes_noted;
        int          frames_closed;

        function new();
            crc = crcmb_pkg::CRC_INIT;
            frame_open = 0;
            mismatches = 0;
            chars_checked = 0;
            bytes_noted = 0;
            frames_closed = 0;
        endfunction

        // LSB-first update with the reflected polynomial
        function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            repeat (8)
            begin
                r = r[0] ? ((r >> 1) ^ crcmb_pkg::CRC_POLY) : (r >> 1);
            end
            return r;
        endfunction

        function logic [7:0] hex_ascii(logic [3:0] nib);
            return (nib < 4'd10) ? (8'h30 + nib) : (8'h37 + nib);
        endfunction

        function void owe(logic [7:0] ch, logic eof);
            frame_char_t fc;
            fc.ch = ch;
            fc.eof = eof;
            owed_chars.push_back(fc);
        endfunction

        // accepted request: queue the characters it must produce
        function void note_byte(logic [7:0] b, logic last);
            bytes_noted++;
            if (!frame_open)
            begin
                crc = crcmb_pkg::CRC_INIT;
                frame_open = 1;
                owe(crcmb_pkg::CH_OPEN, 1'b0);
            end
            owe(b, 1'b0);
            crc = crc_update(crc, b);
            if (last)
            begin
                owe(crcmb_pkg::CH_SEP, 1'b0);
                owe(hex_ascii(crc[15:12]), 1'b0);
                owe(hex_ascii(crc[11:8]), 1'b0);
                owe(hex_ascii(crc[7:4]), 1'b0);
                owe(hex_ascii(crc[3:0]), 1'b0);
                owe(crcmb_pkg::CH_CLOSE, 1'b1);
                frame_open = 0;
                crc = crcmb_pkg::CRC_INIT;
                frames_closed++;
            end
        endfunction

        // accepted result: compare against the oldest owed character
        function void check_char(logic [7:0] ch, logic eof);
            frame_char_t want;
            chars_checked++;
            if (owed_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: char %02h eof %0b arrived with nothing expected", ch, eof);
                return;
            end
            want = owed_chars.pop_front();
            if (ch !== want.ch || eof !== want.eof)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: char #%0d: out_char exp %02h got %02h, ",
                              "end_of_frame exp %0b got %0b"},
                             chars_checked, want.ch, ch, want.eof, eof);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_char;
    logic       end_of_frame;

    int              send_idle_pct;
    int              recv_stall_pct;
    int              cycle_count;
    frame_scoreboard sb;

    crc16_modbus_hex_framer_core u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_char     (out_char),
        .end_of_frame (end_of_frame)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d characters still owed",
                     cycle_count, sb.owed_chars.size());
            $display("crc16_modbus_hex_framer_core test failed");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_char(out_char, end_of_frame);
    end

    // one request: optional idle gap, then hold valid until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b, last);
    endtask

    // sender holds off until every owed character is out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.owed_chars.size() != 0)
            @(posedge clk);
    endtask

    // payload bytes biased toward framing characters and extremes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(15))
            0: return crcmb_pkg::CH_OPEN;
            1: return crcmb_pkg::CH_SEP;
            2: return crcmb_pkg::CH_CLOSE;
            3: return 8'h00;
            4: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // whole frames, mostly short, a few long
    task automatic send_random_frames(input int byte_budget);
        int sent;
        int len;
        sent = 0;
        while (sent < byte_budget)
        begin
            len = ($urandom_range(9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            for (int i = 0; i < len; i++)
                send_byte(pick_byte(), i == len - 1);
            sent += len;
        end
    endtask

    initial
    begin
        logic [7:0] singles[5];
        sb = new();
        cycle_count = 0;
        send_idle_pct = 13;
        recv_stall_pct = 49;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        last_byte = 1'b0;
        out_ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single-byte frames: extremes and payload equal to framing characters
        singles = '{8'h00, 8'hFF, crcmb_pkg::CH_OPEN, crcmb_pkg::CH_SEP, crcmb_pkg::CH_CLOSE};
        foreach (singles[i])
            send_byte(singles[i], 1'b1);
        // standard check string "123456789"
        for (int i = 0; i < 9; i++)
            send_byte(8'h31 + 8'(i), i == 8);
        // short multi-byte frames with every bit toggling
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        drain();

        send_random_frames(PHASE_BYTES);
        drain();

        send_idle_pct = 49;
        recv_stall_pct = 13;
        send_random_frames(PHASE_BYTES);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random_frames(PHASE_BYTES);

        // wind down
        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d payload bytes in %0d frames; checked %0d output characters.",
                 sb.bytes_noted, sb.frames_closed, sb.chars_checked);
        $display("Covered sender gaps, receiver stalls, full-rate streaming; %0d mismatches.",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.owed_chars.size() == 0)
            $display("crc16_modbus_hex_framer_core test passed");
        else
            $display("crc16_modbus_hex_framer_core test failed");
        $finish;
    end

endmodule
